// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rcia_pkg.sv
// ----------------------------------------------------------------------------
// rcia_pkg
// Types and constants shared by the index allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcia_pkg;

  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int COUNT_W    = 16;
  localparam int IN_INDEX_W = 7;
  localparam int REQ_W      = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_EXIT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_REL
  } state_t;

  // Result of the find-first-zero unit.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_res_t;

endpackage

// File: rtl/refcounted_index_allocator_unit.sv
// ----------------------------------------------------------------------------
// refcounted_index_allocator_unit
// Hands out small indices from a free bitmap, with a hold count per requester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A command word is taken when start is high and busy is low. Its result
// word appears on granted_index, status and hold_count_out, which keep it
// until the next result, with done high for exactly one cycle; there is no
// way to hold it off, so sample it then. After reset the block sweeps both
// tables clear and keeps busy high until the sweep is done.
// On acceptance the requester table is read, and its entry is decided in
// S_LOOK, after which most commands are ready for the next word. A free
// that drops the count to zero, and an exit that holds an index, add the
// S_REL state for the bitmap read-modify-write. An allocate by an idle
// requester scans the bitmap one 64-bit word per cycle through the shared
// find-first-zero unit, checking word zero in S_LOOK and each later word in
// S_SCAN, up to the last word.
// done rises the cycle after the decision, so it may coincide with busy low
// and the next word being accepted.
module refcounted_index_allocator_unit import rcia_pkg::*; #(
  parameter int NUM_INDICES    = 128,
  parameter int NUM_REQUESTERS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op,
  input  logic [REQ_W-1:0]      requester,
  input  logic [IN_INDEX_W-1:0] free_index,
  output logic                  done,
  output logic [IN_INDEX_W-1:0] granted_index,
  output logic [1:0]            status,
  output logic [COUNT_W-1:0]    hold_count_out
);

  // Bitmap geometry
  localparam int BW   = (NUM_INDICES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW  = (BW > 1) ? $clog2(BW) : 1;
  localparam int HIW  = $clog2(BW * WORD_BITS);
  // Requester table geometry
  localparam int RAW  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int EW   = HIW + COUNT_W;
  // Clearing sweep
  localparam int CLR  = (NUM_REQUESTERS > BW) ? NUM_REQUESTERS : BW;
  localparam int CLW  = (CLR > 1) ? $clog2(CLR) : 1;
  // Width for comparing a held index with the freed index
  localparam int CMPW = (HIW > IN_INDEX_W) ? HIW : IN_INDEX_W;

  // Sequencer and command registers
  state_t                state, state_next;
  op_t                   cur_op, cur_op_next;
  logic [RAW-1:0]        cur_req, cur_req_next;
  logic                  cur_in_range, cur_in_range_next;
  logic [IN_INDEX_W-1:0] cur_fidx, cur_fidx_next;
  logic [HIW-1:0]        cur_held, cur_held_next;
  logic [WAW-1:0]        scan_addr, scan_addr_next;
  logic [CLW-1:0]        clr_cnt, clr_cnt_next;

  // Result word staging
  logic                  fire;
  logic [IN_INDEX_W-1:0] fire_index;
  status_t               fire_status;
  logic [COUNT_W-1:0]    fire_count;

  // Requester table port
  logic           tab_we, tab_re;
  logic [RAW-1:0] tab_waddr, tab_raddr;
  logic [EW-1:0]  tab_wdata, tab_rdata;

  // Bitmap port
  logic                 bm_we, bm_re;
  logic [WAW-1:0]       bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;

  // Decoded table entry and scan candidate
  logic [HIW-1:0]        ent_held;
  logic [COUNT_W-1:0]    ent_count;
  logic [IN_INDEX_W-1:0] ent_held_out;
  ffz_res_t              scan_res;
  logic [HIW-1:0]        cand;
  logic                  cand_ok;
  logic                  scan_last;

  rcia_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_REQUESTERS)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  rcia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BW)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // Shared find-first-zero unit, fed with whichever bitmap word was read last.
  rcia_ffz u_ffz (
    .word (bm_rdata),
    .res  (scan_res)
  );

  assign ent_held     = tab_rdata[EW-1:COUNT_W];
  assign ent_count    = tab_rdata[COUNT_W-1:0];
  assign ent_held_out = IN_INDEX_W'(ent_held);

  // Index of the lowest clear bit in the current word; bits beyond the
  // configured index count never qualify.
  assign cand      = HIW'({scan_addr, scan_res.pos});
  assign cand_ok   = scan_res.found && ({1'b0, cand} < (HIW + 1)'(NUM_INDICES));
  assign scan_last = (scan_addr == WAW'(BW - 1));

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op       <= cur_op_next;
    cur_req      <= cur_req_next;
    cur_in_range <= cur_in_range_next;
    cur_fidx     <= cur_fidx_next;
    cur_held     <= cur_held_next;
    scan_addr    <= scan_addr_next;
  end

  // Result word: strobe for one cycle, payload held until the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_index  <= fire_index;
      status         <= fire_status;
      hold_count_out <= fire_count;
    end
  end

  always_comb begin
    state_next        = state;
    cur_op_next       = cur_op;
    cur_req_next      = cur_req;
    cur_in_range_next = cur_in_range;
    cur_fidx_next     = cur_fidx;
    cur_held_next     = cur_held;
    scan_addr_next    = scan_addr;
    clr_cnt_next      = clr_cnt;

    tab_we    = 1'b0;
    tab_waddr = cur_req;
    tab_wdata = '0;
    tab_re    = 1'b0;
    tab_raddr = RAW'(requester);

    bm_we    = 1'b0;
    bm_waddr = scan_addr;
    bm_wdata = '0;
    bm_re    = 1'b0;
    bm_raddr = '0;

    fire        = 1'b0;
    fire_index  = '0;
    fire_status = ST_OK;
    fire_count  = '0;

    unique case (state)
      S_CLEAR: begin
        // Zero one table entry and one bitmap word per cycle.
        tab_we       = (32'(clr_cnt) < NUM_REQUESTERS);
        tab_waddr    = RAW'(clr_cnt);
        bm_we        = (32'(clr_cnt) < BW);
        bm_waddr     = WAW'(clr_cnt);
        clr_cnt_next = CLW'(clr_cnt + 1'b1);
        if (clr_cnt == CLW'(CLR - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          cur_op_next       = op_t'(op);
          cur_req_next      = RAW'(requester);
          cur_in_range_next = (32'(requester) < NUM_REQUESTERS);
          cur_fidx_next     = free_index;
          scan_addr_next    = '0;
          tab_re            = 1'b1;
          bm_re             = 1'b1;
          bm_raddr          = '0;
          state_next        = S_LOOK;
        end
      end

      S_LOOK: begin
        cur_held_next = ent_held;
        state_next    = S_IDLE;
        if (!cur_in_range) begin
          fire        = 1'b1;
          fire_status = ST_MISMATCH;
        end else begin
          unique case (cur_op)
            OP_ALLOC: begin
              if (ent_count != '0) begin
                fire       = 1'b1;
                fire_index = ent_held_out;
                if (ent_count == COUNT_MAX) begin
                  // Saturate and flag; the entry stays as it is.
                  fire_status = ST_OVERFLOW;
                  fire_count  = COUNT_MAX;
                end else begin
                  tab_we     = 1'b1;
                  tab_wdata  = {ent_held, COUNT_W'(ent_count + 1'b1)};
                  fire_count = COUNT_W'(ent_count + 1'b1);
                end
              end else if (cand_ok) begin
                // Word zero already holds a usable clear bit.
                bm_we       = 1'b1;
                bm_waddr    = scan_addr;
                bm_wdata    = bm_rdata | (WORD_BITS'(1) << scan_res.pos);
                tab_we      = 1'b1;
                tab_wdata   = {cand, COUNT_W'(1)};
                fire        = 1'b1;
                fire_index  = IN_INDEX_W'(cand);
                fire_count  = COUNT_W'(1);
              end else if (!scan_res.found && !scan_last) begin
                scan_addr_next = WAW'(scan_addr + 1'b1);
                bm_re          = 1'b1;
                bm_raddr       = WAW'(scan_addr + 1'b1);
                state_next     = S_SCAN;
              end else begin
                fire        = 1'b1;
                fire_status = ST_NO_FREE;
              end
            end

            OP_FREE: begin
              if (ent_count == '0 || CMPW'(ent_held) != CMPW'(cur_fidx)) begin
                fire        = 1'b1;
                fire_status = ST_MISMATCH;
                fire_index  = (ent_count != '0) ? ent_held_out : '0;
                fire_count  = ent_count;
              end else if (ent_count == COUNT_W'(1)) begin
                // Last hold goes: drop the entry and release the bit.
                tab_we     = 1'b1;
                tab_wdata  = '0;
                bm_re      = 1'b1;
                bm_raddr   = WAW'(ent_held >> BIT_W);
                state_next = S_REL;
              end else begin
                tab_we     = 1'b1;
                tab_wdata  = {ent_held, COUNT_W'(ent_count - 1'b1)};
                fire       = 1'b1;
                fire_index = ent_held_out;
                fire_count = COUNT_W'(ent_count - 1'b1);
              end
            end

            OP_EXIT: begin
              tab_we    = 1'b1;
              tab_wdata = '0;
              if (ent_count != '0) begin
                bm_re      = 1'b1;
                bm_raddr   = WAW'(ent_held >> BIT_W);
                state_next = S_REL;
              end else begin
                fire = 1'b1;
              end
            end

            default: begin
              // Unused code: report the entry and change nothing.
              fire       = 1'b1;
              fire_index = (ent_count != '0) ? ent_held_out : '0;
              fire_count = ent_count;
            end
          endcase
        end
      end

      S_SCAN: begin
        state_next = S_IDLE;
        if (cand_ok) begin
          bm_we      = 1'b1;
          bm_waddr   = scan_addr;
          bm_wdata   = bm_rdata | (WORD_BITS'(1) << scan_res.pos);
          tab_we     = 1'b1;
          tab_wdata  = {cand, COUNT_W'(1)};
          fire       = 1'b1;
          fire_index = IN_INDEX_W'(cand);
          fire_count = COUNT_W'(1);
        end else if (!scan_res.found && !scan_last) begin
          // Word full: advance to the next one.
          scan_addr_next = WAW'(scan_addr + 1'b1);
          bm_re          = 1'b1;
          bm_raddr       = WAW'(scan_addr + 1'b1);
          state_next     = S_SCAN;
        end else begin
          fire        = 1'b1;
          fire_status = ST_NO_FREE;
        end
      end

      S_REL: begin
        // Clear the released bit in the word read last cycle.
        bm_we      = 1'b1;
        bm_waddr   = WAW'(cur_held >> BIT_W);
        bm_wdata   = bm_rdata & ~(WORD_BITS'(1) << cur_held[BIT_W-1:0]);
        fire       = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_raises_busy, clk, rst, start && !busy, busy,
               "accepted command word did not raise busy")
  `ASSERT_SAME(a_done_after_work, clk, rst, done, $past(busy),
               "result word without a command in progress")
  `ASSERT_SAME(a_zero_count_zero_index, clk, rst, done && hold_count_out == '0,
               granted_index == '0, "index reported with a zero hold count")
  `ASSERT_SAME(a_no_free_empty, clk, rst, done && status == ST_NO_FREE,
               hold_count_out == '0, "no free index reported with a hold count")

endmodule

// File: rtl/rcia_ram.sv
// ----------------------------------------------------------------------------
// rcia_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rcia_ffz.sv
// ----------------------------------------------------------------------------
// rcia_ffz
// Find-first-zero over one bitmap word: lowest clear bit and whether any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcia_ffz import rcia_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  output ffz_res_t             res
);

  // Walk from the top so the lowest clear bit wins.
  always_comb begin
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = BIT_W'(i);
      end
    end
  end

endmodule
